/* src/sik_pkg.sv */
// Package for the swerve drive inverse kinematics block.
// Payload types, pipeline depths and the CORDIC arctangent table; no dependencies.
package sik_pkg;

  localparam int MODULES      = 4;
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 30;
  localparam int ANGLE_DELAY  = 8;
  localparam int LATENCY      = 36;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_BASE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACK_WIDTH = 8'd1;

  localparam logic [11:0] WHEEL_BASE_RESET  = 12'd933;
  localparam logic [11:0] TRACK_WIDTH_RESET = 12'd570;

  localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_lateral;
    logic signed [15:0] yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic        [15:0] speed_front_right;
    logic        [15:0] speed_front_left;
    logic        [15:0] speed_back_left;
    logic        [15:0] speed_back_right;
    logic signed [15:0] angle_front_right;
    logic signed [15:0] angle_front_left;
    logic signed [15:0] angle_back_left;
    logic signed [15:0] angle_back_right;
  } wheel_t;

endpackage

/* src/swerve_inverse_kinematics.sv */
// Top level of the swerve drive inverse kinematics block.
// Needs sik_pkg for payload types, depths and the arctangent table.
//
//   channel   handshake              payload
//   command   start / busy           cmd      (sik_pkg::cmd_t)
//   result    done (one cycle)       result   (sik_pkg::wheel_t)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command per cycle.
// The speed path runs through the input stages (cmd_q, vx_q, cx, ax, sqx, n_s),
// the 30-stage square root, one result bit per stage, and the output register.
// busy stays low and cfg_ready stays high; there is no stall on either side.
// rst clears the valid chain and loads the geometry register defaults.
module swerve_inverse_kinematics (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  sik_pkg::cmd_t                       cmd,
  output logic                                done,
  output sik_pkg::wheel_t                     result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sik_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sik_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NM = sik_pkg::MODULES;
  localparam int NC = sik_pkg::CORDIC_STEPS;
  localparam int NS = sik_pkg::SQRT_STEPS;
  localparam int ND = sik_pkg::ANGLE_DELAY;
  localparam int LAT = sik_pkg::LATENCY;

  logic [11:0] wheel_base;
  logic [11:0] track_width;
  logic [LAT:0] vld;

  sik_pkg::cmd_t cmd_q;
  logic signed [28:0] vx_q, vy_q, pw_q, pl_q;
  logic signed [31:0] cx [NM];
  logic signed [31:0] cy [NM];

  logic [28:0] ax [NM];
  logic [28:0] ay [NM];
  logic [57:0] sqx [NM];
  logic [57:0] sqy [NM];

  logic signed [31:0] cx_s [NM][NC+1];
  logic signed [31:0] cy_s [NM][NC+1];
  logic [31:0]        acc_s [NM][NC+1];
  logic               zero_s [NM][NC+1];

  logic [59:0] n_s [NM][NS+1];
  logic [31:0] rem_s [NM][NS+1];
  logic [29:0] root_s [NM][NS+1];

  logic [15:0] ang_d [NM][ND];
  logic [15:0] speed [NM];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign done = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_base <= sik_pkg::WHEEL_BASE_RESET;
      track_width <= sik_pkg::TRACK_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == sik_pkg::REG_WHEEL_BASE) wheel_base <= cfg_data[11:0];
      else if (cfg_index == sik_pkg::REG_TRACK_WIDTH) track_width <= cfg_data[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-1:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    cmd_q <= cmd;
    vx_q <= {cmd_q.vel_forward, 13'd0};
    vy_q <= {cmd_q.vel_lateral, 13'd0};
    pw_q <= 29'($signed(cmd_q.yaw_rate) * $signed({1'b0, track_width}));
    pl_q <= 29'($signed(cmd_q.yaw_rate) * $signed({1'b0, wheel_base}));
    cx[0] <= 32'(vx_q) + 32'(pw_q);
    cy[0] <= 32'(vy_q) + 32'(pl_q);
    cx[1] <= 32'(vx_q) - 32'(pw_q);
    cy[1] <= 32'(vy_q) + 32'(pl_q);
    cx[2] <= 32'(vx_q) - 32'(pw_q);
    cy[2] <= 32'(vy_q) - 32'(pl_q);
    cx[3] <= 32'(vx_q) + 32'(pw_q);
    cy[3] <= 32'(vy_q) - 32'(pl_q);
  end

  for (genvar m = 0; m < NM; m++) begin : g_mod
    logic [30:0] spd_sum;
    logic [31:0] acc_rnd;

    always_ff @(posedge clk) begin
      ax[m] <= cx[m][31] ? 29'(-cx[m]) : cx[m][28:0];
      ay[m] <= cy[m][31] ? 29'(-cy[m]) : cy[m][28:0];
      cx_s[m][0] <= cx[m][31] ? -cx[m] : cx[m];
      cy_s[m][0] <= cx[m][31] ? -cy[m] : cy[m];
      acc_s[m][0] <= cx[m][31] ? 32'h8000_0000 : 32'd0;
      zero_s[m][0] <= (cx[m] == 32'sd0) && (cy[m] == 32'sd0);
      sqx[m] <= ax[m] * ax[m];
      sqy[m] <= ay[m] * ay[m];
      n_s[m][0] <= {2'b00, sqx[m]} + {2'b00, sqy[m]};
      rem_s[m][0] <= '0;
      root_s[m][0] <= '0;
    end

    for (genvar i = 0; i < NC; i++) begin : g_cordic
      always_ff @(posedge clk) begin
        zero_s[m][i+1] <= zero_s[m][i];
        if (!cy_s[m][i][31]) begin
          cx_s[m][i+1] <= cx_s[m][i] + (cy_s[m][i] >>> i);
          cy_s[m][i+1] <= cy_s[m][i] - (cx_s[m][i] >>> i);
          acc_s[m][i+1] <= acc_s[m][i] + sik_pkg::ATAN_TABLE[i];
        end else begin
          cx_s[m][i+1] <= cx_s[m][i] - (cy_s[m][i] >>> i);
          cy_s[m][i+1] <= cy_s[m][i] + (cx_s[m][i] >>> i);
          acc_s[m][i+1] <= acc_s[m][i] - sik_pkg::ATAN_TABLE[i];
        end
      end
    end

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
      logic [33:0] nrem;
      logic [33:0] trial;
      assign nrem = {rem_s[m][k], n_s[m][k][59:58]};
      assign trial = {2'b00, root_s[m][k], 2'b01};
      always_ff @(posedge clk) begin
        n_s[m][k+1] <= {n_s[m][k][57:0], 2'b00};
        if (nrem >= trial) begin
          rem_s[m][k+1] <= 32'(nrem - trial);
          root_s[m][k+1] <= {root_s[m][k][28:0], 1'b1};
        end else begin
          rem_s[m][k+1] <= nrem[31:0];
          root_s[m][k+1] <= {root_s[m][k][28:0], 1'b0};
        end
      end
    end

    assign acc_rnd = acc_s[m][NC] + 32'h0000_8000;

    always_ff @(posedge clk) begin
      ang_d[m][0] <= zero_s[m][NC] ? 16'd0 : acc_rnd[31:16];
      for (int d = 1; d < ND; d++) ang_d[m][d] <= ang_d[m][d-1];
    end

    assign spd_sum = {1'b0, root_s[m][NS]} + 31'd4096;
    assign speed[m] = (spd_sum[30:13] > 18'd65535) ? 16'hFFFF : spd_sum[28:13];
  end

  always_ff @(posedge clk) begin
    result.speed_front_right <= speed[0];
    result.speed_front_left <= speed[1];
    result.speed_back_left <= speed[2];
    result.speed_back_right <= speed[3];
    result.angle_front_right <= ang_d[0][ND-1];
    result.angle_front_left <= ang_d[1][ND-1];
    result.angle_back_left <= ang_d[2][ND-1];
    result.angle_back_right <= ang_d[3][ND-1];
  end

  a_done_has_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT + 1))
    else $error("result without a command transaction");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    vld[3] && zero_s[0][0] |-> ##33 (done && result.angle_front_right == 16'd0))
    else $error("zero module velocity gave a nonzero angle");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    vld[LAT-1] |-> ({1'b0, rem_s[0][NS]} <= {2'b00, root_s[0][NS], 1'b0}))
    else $error("square root remainder out of bound");

endmodule

/* verif/tb.sv */
// Testbench for swerve_inverse_kinematics: directed and random velocity commands under
// several geometry settings, each result checked against a bit-exact predictor.
// Depends on sik_pkg and the swerve_inverse_kinematics RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [sik_pkg::CFG_INDEX_W-1:0] REG_NONE = 8'd7;
  localparam int RANDOM_PER_PHASE = 280;

  class wheel_scoreboard;
    logic [11:0] wheel_base;
    logic [11:0] track_width;
    sik_pkg::wheel_t expected_wheels[$];
    int mismatches;
    int unexpected;
    int commands;
    int results;

    function new();
      wheel_base  = sik_pkg::WHEEL_BASE_RESET;
      track_width = sik_pkg::TRACK_WIDTH_RESET;
      mismatches  = 0;
      unexpected  = 0;
      commands    = 0;
      results     = 0;
    endfunction

    function void write_reg(logic [sik_pkg::CFG_INDEX_W-1:0] index,
                            logic [sik_pkg::CFG_DATA_W-1:0] data);
      if (index == sik_pkg::REG_WHEEL_BASE) wheel_base = data[11:0];
      else if (index == sik_pkg::REG_TRACK_WIDTH) track_width = data[11:0];
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function automatic logic [15:0] wheel_speed(longint signed cx, longint signed cy);
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned s;
      ax = (cx < 0) ? -cx : cx;
      ay = (cy < 0) ? -cy : cy;
      s = (root_floor(ax * ax + ay * ay) + 4096) >> 13;
      return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [15:0] steer_angle(longint signed cx, longint signed cy);
      logic [31:0] acc;
      longint signed dx;
      longint signed dy;
      acc = '0;
      if (cx == 0 && cy == 0) return 16'd0;
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        acc = 32'h8000_0000;
      end
      for (int i = 0; i < sik_pkg::CORDIC_STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          acc = acc + sik_pkg::ATAN_TABLE[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          acc = acc - sik_pkg::ATAN_TABLE[i];
        end
      end
      acc = acc + 32'h8000;
      return acc[31:16];
    endfunction

    function void note_command(sik_pkg::cmd_t c);
      longint signed vx;
      longint signed vy;
      longint signed w;
      longint signed cx[sik_pkg::MODULES];
      longint signed cy[sik_pkg::MODULES];
      sik_pkg::wheel_t e;
      vx = longint'(c.vel_forward) * 8192;
      vy = longint'(c.vel_lateral) * 8192;
      w  = longint'(c.yaw_rate);
      // front right, front left, back left, back right
      cx[0] = vx + w * track_width;  cy[0] = vy + w * wheel_base;
      cx[1] = vx - w * track_width;  cy[1] = vy + w * wheel_base;
      cx[2] = vx - w * track_width;  cy[2] = vy - w * wheel_base;
      cx[3] = vx + w * track_width;  cy[3] = vy - w * wheel_base;
      e.speed_front_right = wheel_speed(cx[0], cy[0]);
      e.speed_front_left  = wheel_speed(cx[1], cy[1]);
      e.speed_back_left   = wheel_speed(cx[2], cy[2]);
      e.speed_back_right  = wheel_speed(cx[3], cy[3]);
      e.angle_front_right = steer_angle(cx[0], cy[0]);
      e.angle_front_left  = steer_angle(cx[1], cy[1]);
      e.angle_back_left   = steer_angle(cx[2], cy[2]);
      e.angle_back_right  = steer_angle(cx[3], cy[3]);
      expected_wheels.push_back(e);
      commands++;
    endfunction

    function void check_result(sik_pkg::wheel_t got);
      sik_pkg::wheel_t e;
      logic [7:0][15:0] ef;
      logic [7:0][15:0] gf;
      string names[8];
      bit bad;
      names = '{"angle_back_right", "angle_back_left", "angle_front_left",
                "angle_front_right", "speed_back_right", "speed_back_left",
                "speed_front_left", "speed_front_right"};
      results++;
      if (expected_wheels.size() == 0) begin
        unexpected++;
        $display("ERROR: result with no command outstanding: %h", got);
        return;
      end
      e = expected_wheels.pop_front();
      ef = e;
      gf = got;
      bad = 0;
      for (int f = 7; f >= 0; f--) begin
        if (ef[f] !== gf[f]) begin
          bad = 1;
          if (mismatches < 10)
            $display("ERROR: %s expected %0d (%h) got %0d (%h)",
                     names[f], ef[f], ef[f], gf[f], gf[f]);
        end
      end
      if (bad) mismatches++;
    endfunction

    function int outstanding();
      return expected_wheels.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  sik_pkg::cmd_t cmd;
  logic done;
  sik_pkg::wheel_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [sik_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sik_pkg::CFG_DATA_W-1:0] cfg_data;

  wheel_scoreboard sb;
  sik_pkg::cmd_t cmd_fifo[$];
  int phases;

  swerve_inverse_kinematics i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_command(cmd);
      if (done) sb.check_result(result);
    end
  end

  function automatic logic [15:0] pick_value(int mode);
    logic [15:0] v;
    case (mode)
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 600) - 300);
      default: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'hFFFF;
          default: v = 16'h0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic sik_pkg::cmd_t random_cmd();
    sik_pkg::cmd_t c;
    int mode;
    mode = $urandom_range(0, 4);
    c.vel_forward = pick_value(mode % 3);
    c.vel_lateral = pick_value(mode % 3);
    c.yaw_rate    = pick_value(mode % 3);
    // pure spin in place
    if (mode == 4) begin
      c.vel_forward = '0;
      c.vel_lateral = '0;
    end
    return c;
  endfunction

  function automatic sik_pkg::cmd_t make_cmd(int vx, int vy, int w);
    sik_pkg::cmd_t c;
    c.vel_forward = 16'(vx);
    c.vel_lateral = 16'(vy);
    c.yaw_rate    = 16'(w);
    return c;
  endfunction

  task automatic play_commands();
    int burst;
    int gap;
    while (cmd_fifo.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && cmd_fifo.size() > 0) begin
        start <= 1'b1;
        cmd   <= cmd_fifo.pop_front();
        do @(posedge clk); while (busy);
        burst--;
      end
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (sik_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_geometry(logic [sik_pkg::CFG_INDEX_W-1:0] index,
                                logic [sik_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int n);
    repeat (n) cmd_fifo.push_back(random_cmd());
    play_commands();
    drain();
    phases++;
  endtask

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    sb = new();
    phases = 0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry: zero, pi, extremes, translation only, spin only
    cmd_fifo.push_back(make_cmd(0, 0, 0));
    cmd_fifo.push_back(make_cmd(-5, 0, 0));
    cmd_fifo.push_back(make_cmd(0, 1, 0));
    cmd_fifo.push_back(make_cmd(0, -1, 0));
    cmd_fifo.push_back(make_cmd(32767, 32767, 32767));
    cmd_fifo.push_back(make_cmd(-32768, -32768, -32768));
    cmd_fifo.push_back(make_cmd(32767, -32768, 0));
    cmd_fifo.push_back(make_cmd(-32768, 32767, 0));
    cmd_fifo.push_back(make_cmd(0, 0, 32767));
    cmd_fifo.push_back(make_cmd(0, 0, -32768));
    cmd_fifo.push_back(make_cmd(1000, 0, 0));
    cmd_fifo.push_back(make_cmd(-1, -1, -1));
    run_phase(RANDOM_PER_PHASE);

    // largest geometry: saturation of the wheel speed
    write_geometry(sik_pkg::REG_WHEEL_BASE, 16'h0FFF);
    write_geometry(sik_pkg::REG_TRACK_WIDTH, 16'h0FFF);
    cmd_fifo.push_back(make_cmd(-32768, -32768, -32768));
    cmd_fifo.push_back(make_cmd(32767, 32767, 32767));
    cmd_fifo.push_back(make_cmd(32767, -32768, -32768));
    cmd_fifo.push_back(make_cmd(0, 0, 1));
    run_phase(RANDOM_PER_PHASE);

    // zero geometry: yaw has no effect, zero module velocity with spin
    write_geometry(sik_pkg::REG_WHEEL_BASE, 16'h0000);
    write_geometry(sik_pkg::REG_TRACK_WIDTH, 16'h0000);
    cmd_fifo.push_back(make_cmd(0, 0, 32767));
    cmd_fifo.push_back(make_cmd(0, 0, -32768));
    cmd_fifo.push_back(make_cmd(-7, 0, 1234));
    run_phase(RANDOM_PER_PHASE);

    // upper data bits dropped, unused index ignored
    write_geometry(sik_pkg::REG_WHEEL_BASE, {4'hF, 12'($urandom)});
    write_geometry(sik_pkg::REG_TRACK_WIDTH, {4'hA, 12'($urandom)});
    write_geometry(REG_NONE, 16'h0123);
    run_phase(RANDOM_PER_PHASE);

    write_geometry(sik_pkg::REG_WHEEL_BASE, 16'($urandom_range(1, 300)));
    write_geometry(sik_pkg::REG_TRACK_WIDTH, 16'($urandom));
    run_phase(RANDOM_PER_PHASE);

    $display("Ran %0d commands over %0d geometry settings, %0d results checked.",
             sb.commands, phases, sb.results);
    $display("Mismatches %0d, unexpected results %0d, outstanding %0d.",
             sb.mismatches, sb.unexpected, sb.outstanding());
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
